### src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types and codes for the I2C master pin sequencer: the transfer
// payloads, command codes, sequence step codes and register reset values.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // Command codes carried in the action field
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;
   localparam logic [2:0] ACT_PROBE = 3'd5;

   // Sequence steps: start phases, per-bit phases, stop phases
   localparam logic [4:0] STEP_IDLE          = 5'd0;
   localparam logic [4:0] STEP_START_SCL_LO  = 5'd1;
   localparam logic [4:0] STEP_START_SDA_HI  = 5'd2;
   localparam logic [4:0] STEP_START_SCL_HI  = 5'd3;
   localparam logic [4:0] STEP_START_SDA_LO  = 5'd4;
   localparam logic [4:0] STEP_START_SCL_LO2 = 5'd5;
   localparam logic [4:0] STEP_START_END     = 5'd6;
   localparam logic [4:0] STEP_BIT_SETUP     = 5'd7;
   localparam logic [4:0] STEP_BIT_HIGH      = 5'd8;
   localparam logic [4:0] STEP_BIT_LOW       = 5'd9;
   localparam logic [4:0] STEP_STOP_SCL_LO   = 5'd10;
   localparam logic [4:0] STEP_STOP_SDA_LO   = 5'd11;
   localparam logic [4:0] STEP_STOP_SCL_HI   = 5'd12;
   localparam logic [4:0] STEP_STOP_SDA_HI   = 5'd13;
   localparam logic [4:0] STEP_STOP_END      = 5'd14;

   // Bit index of the acknowledge bit after eight data bits
   localparam logic [3:0] ACK_BIT_INDEX = 4'd8;

   // Reset value of the phase length register
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd20;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_byte;
      logic       ack_send;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
      logic       rejected;
   } rsp_type;

endpackage

### src/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Pin sequencer for an I2C master: start, stop, write byte, read byte and
// address probe, advanced by tick transfers with a configurable phase length.
// ----------------------------------------------------------------------------
// One request transfer gives exactly one response transfer showing the pin
// and status state after that request. Requests are taken one per clock
// unless rsp_ready holds them back: each one is registered, runs through
// the sequencer update logic and lands in the response register, and a
// new request is taken while an earlier response still waits for
// rsp_ready. Commands start a sequence; tick requests (action 0) move
// it, each wait lasting phase_ticks ticks (0 behaves as 1). A command that
// arrives while a sequence runs is flagged rejected and otherwise ignored.
// The user must write the phase length register through the csr channel
// only while no request is in flight; the block does not enforce this.
module i2c_master_bit_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cms_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cms_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data
);

   // Pipeline control and payload registers
   logic                in_valid_ff;
   i2cms_pkg::req_type  in_item_ff;
   logic                out_valid_ff;
   i2cms_pkg::rsp_type  out_item_ff;
   logic                advance;

   // Sequencer state
   logic [15:0] phase_ticks_ff;
   logic [15:0] phase_timer_ff, phase_timer_in;
   logic [4:0]  step_ff, step_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic        pend_ack_ff, pend_ack_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        sda_rel_ff, sda_rel_in;
   logic        ack_cap_ff, ack_cap_in;
   logic        busy_ff, busy_in;
   logic [7:0]  rx_hold_ff, rx_hold_in;
   logic        done_in, rej_in;
   i2cms_pkg::rsp_type rsp_in;

   // Handshakes
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;
   assign csr_ready = 1'b1;

   // Hold the incoming request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // Phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cms_pkg::PHASE_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         phase_ticks_ff <= csr_data;
      end
   end

   // Sequencer update for the registered request
   always_comb begin
      logic rd;
      logic fin;
      logic [3:0] nxt_idx;
      phase_timer_in = phase_timer_ff;
      step_in        = step_ff;
      bit_index_in   = bit_index_ff;
      shift_in       = shift_ff;
      cmd_in         = cmd_ff;
      pend_ack_in    = pend_ack_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      sda_rel_in     = sda_rel_ff;
      ack_cap_in     = ack_cap_ff;
      busy_in        = busy_ff;
      rx_hold_in     = rx_hold_ff;
      done_in        = 1'b0;
      rej_in         = 1'b0;
      fin            = 1'b0;
      rd = (cmd_ff == i2cms_pkg::ACT_READ) ? (bit_index_ff < i2cms_pkg::ACK_BIT_INDEX)
                                           : (bit_index_ff >= i2cms_pkg::ACK_BIT_INDEX);
      nxt_idx = bit_index_ff + 4'd1;

      if (in_item_ff.action == i2cms_pkg::ACT_TICK) begin
         if (busy_ff) begin
            if (phase_timer_ff > 16'd1) begin
               // count down the current wait
               phase_timer_in = phase_timer_ff - 16'd1;
            end else begin
               // wait over: apply the next pin change
               phase_timer_in = phase_ticks_ff;
               unique case (step_ff)
                  i2cms_pkg::STEP_START_SCL_LO: begin
                     scl_in  = 1'b0;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_START_SDA_HI: begin
                     sda_in  = 1'b1;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_START_SCL_HI: begin
                     scl_in  = 1'b1;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_START_SDA_LO: begin
                     sda_in  = 1'b0;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_START_SCL_LO2: begin
                     scl_in  = 1'b0;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_START_END: begin
                     if (cmd_ff != i2cms_pkg::ACT_PROBE) begin
                        fin = 1'b1;
                     end else begin
                        step_in      = i2cms_pkg::STEP_BIT_SETUP;
                        bit_index_in = 4'd0;
                     end
                  end
                  i2cms_pkg::STEP_BIT_SETUP: begin
                     if (rd) begin
                        sda_rel_in = 1'b1;
                        scl_in     = 1'b1;
                     end else if (bit_index_ff < i2cms_pkg::ACK_BIT_INDEX) begin
                        sda_in   = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0};
                     end else begin
                        sda_in = pend_ack_ff;
                     end
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_BIT_HIGH: begin
                     if (rd) begin
                        if (bit_index_ff < i2cms_pkg::ACK_BIT_INDEX) begin
                           shift_in = {shift_ff[6:0], in_item_ff.sda_in};
                        end else begin
                           ack_cap_in = in_item_ff.sda_in;
                        end
                        scl_in = 1'b0;
                     end else begin
                        scl_in = 1'b1;
                     end
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_BIT_LOW: begin
                     if (rd) begin
                        sda_rel_in = 1'b0;
                     end else begin
                        scl_in = 1'b0;
                     end
                     bit_index_in = nxt_idx;
                     if (nxt_idx <= i2cms_pkg::ACK_BIT_INDEX) begin
                        step_in = i2cms_pkg::STEP_BIT_SETUP;
                     end else if (cmd_ff == i2cms_pkg::ACT_READ) begin
                        rx_hold_in = shift_ff;
                        fin        = 1'b1;
                     end else if (cmd_ff == i2cms_pkg::ACT_PROBE) begin
                        step_in = i2cms_pkg::STEP_STOP_SCL_LO;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  i2cms_pkg::STEP_STOP_SCL_LO: begin
                     scl_in  = 1'b0;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_STOP_SDA_LO: begin
                     sda_in  = 1'b0;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_STOP_SCL_HI: begin
                     scl_in  = 1'b1;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_STOP_SDA_HI: begin
                     sda_in  = 1'b1;
                     step_in = step_ff + 5'd1;
                  end
                  i2cms_pkg::STEP_STOP_END: begin
                     scl_in = 1'b0;
                     fin    = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
               // drop back to idle when the sequence ends
               if (fin) begin
                  busy_in        = 1'b0;
                  step_in        = i2cms_pkg::STEP_IDLE;
                  phase_timer_in = 16'd0;
                  done_in        = 1'b1;
               end
            end
         end
      end else if (in_item_ff.action <= i2cms_pkg::ACT_PROBE) begin
         if (busy_ff) begin
            rej_in = 1'b1;
         end else begin
            // arm a new command sequence
            cmd_in         = in_item_ff.action;
            busy_in        = 1'b1;
            bit_index_in   = 4'd0;
            phase_timer_in = phase_ticks_ff;
            priority if (in_item_ff.action == i2cms_pkg::ACT_STOP) begin
               step_in = i2cms_pkg::STEP_STOP_SCL_LO;
            end else if (in_item_ff.action == i2cms_pkg::ACT_WRITE) begin
               shift_in = in_item_ff.data_byte;
               step_in  = i2cms_pkg::STEP_BIT_SETUP;
            end else if (in_item_ff.action == i2cms_pkg::ACT_READ) begin
               shift_in    = 8'd0;
               pend_ack_in = in_item_ff.ack_send;
               step_in     = i2cms_pkg::STEP_BIT_SETUP;
            end else begin
               if (in_item_ff.action == i2cms_pkg::ACT_PROBE) begin
                  shift_in = in_item_ff.data_byte;
               end
               step_in = i2cms_pkg::STEP_START_SCL_LO;
            end
         end
      end

      rsp_in.scl_level = scl_in;
      rsp_in.sda_level = sda_in;
      rsp_in.sda_drive = !sda_rel_in;
      rsp_in.busy_res  = busy_in;
      rsp_in.done_res  = done_in;
      rsp_in.rx_byte   = rx_hold_in;
      rsp_in.ack_seen  = ack_cap_in;
      rsp_in.rejected  = rej_in;
   end

   // Commit sequencer state when a request moves to the response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_timer_ff <= 16'd0;
         step_ff        <= i2cms_pkg::STEP_IDLE;
         bit_index_ff   <= 4'd0;
         shift_ff       <= 8'd0;
         cmd_ff         <= i2cms_pkg::ACT_TICK;
         pend_ack_ff    <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         sda_rel_ff     <= 1'b0;
         ack_cap_ff     <= 1'b1;
         busy_ff        <= 1'b0;
         rx_hold_ff     <= 8'd0;
      end else if (advance) begin
         phase_timer_ff <= phase_timer_in;
         step_ff        <= step_in;
         bit_index_ff   <= bit_index_in;
         shift_ff       <= shift_in;
         cmd_ff         <= cmd_in;
         pend_ack_ff    <= pend_ack_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         sda_rel_ff     <= sda_rel_in;
         ack_cap_ff     <= ack_cap_in;
         busy_ff        <= busy_in;
         rx_hold_ff     <= rx_hold_in;
      end
   end

   // Hold the response until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_item_ff <= rsp_in;
      end
   end

endmodule

### bench/i2cms_checker.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer checker
// Watches the request, response and csr channels of the sequencer, keeps its
// own model of the pin and status state, and compares every response
// transfer field by field against the oldest predicted state.
// ----------------------------------------------------------------------------
module i2cms_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  i2cms_pkg::req_type  req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  i2cms_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [15:0]         csr_data,
   output int unsigned         mismatches,
   output int unsigned         outstanding,
   output logic                seq_busy
);
   import i2cms_pkg::*;

   // Model state
   logic [15:0] wait_len;
   logic [15:0] countdown;
   logic [4:0]  step;
   logic [3:0]  bit_pos;
   logic [7:0]  shreg;
   logic [2:0]  cmd;
   logic        ack_to_send;
   logic        scl_q;
   logic        sda_q;
   logic        sda_float;
   logic        ack_q;
   logic        running;
   logic [7:0]  rx_last;

   rsp_type     pin_state_q[$];
   rsp_type     wanted;

   // Data bits of a read, or the ack bit of a write, are sampled from the slave
   function automatic logic reading_bit();
      if (cmd == ACT_READ) return bit_pos < ACK_BIT_INDEX;
      return bit_pos >= ACK_BIT_INDEX;
   endfunction

   // Apply the pin change that ends the current wait; 1 when the command is done
   function automatic logic apply_pin_change(input logic sda_sample);
      logic rd;
      rd = reading_bit();
      case (step)
         STEP_START_SCL_LO:  scl_q = 1'b0;
         STEP_START_SDA_HI:  sda_q = 1'b1;
         STEP_START_SCL_HI:  scl_q = 1'b1;
         STEP_START_SDA_LO:  sda_q = 1'b0;
         STEP_START_SCL_LO2: scl_q = 1'b0;
         STEP_START_END: begin
            if (cmd != ACT_PROBE) return 1'b1;
            step    = STEP_BIT_SETUP;
            bit_pos = '0;
            return 1'b0;
         end
         STEP_BIT_SETUP: begin
            if (rd) begin
               sda_float = 1'b1;
               scl_q     = 1'b1;
            end else if (bit_pos < ACK_BIT_INDEX) begin
               sda_q = shreg[7];
               shreg = {shreg[6:0], 1'b0};
            end else begin
               sda_q = ack_to_send;
            end
         end
         STEP_BIT_HIGH: begin
            if (rd) begin
               if (bit_pos < ACK_BIT_INDEX) shreg = {shreg[6:0], sda_sample};
               else ack_q = sda_sample;
               scl_q = 1'b0;
            end else begin
               scl_q = 1'b1;
            end
         end
         STEP_BIT_LOW: begin
            if (rd) sda_float = 1'b0;
            else scl_q = 1'b0;
            bit_pos = bit_pos + 4'd1;
            if (bit_pos <= ACK_BIT_INDEX) begin
               step = STEP_BIT_SETUP;
               return 1'b0;
            end
            if (cmd == ACT_READ) begin
               rx_last = shreg;
               return 1'b1;
            end
            if (cmd == ACT_PROBE) begin
               step = STEP_STOP_SCL_LO;
               return 1'b0;
            end
            return 1'b1;
         end
         STEP_STOP_SCL_LO: scl_q = 1'b0;
         STEP_STOP_SDA_LO: sda_q = 1'b0;
         STEP_STOP_SCL_HI: scl_q = 1'b1;
         STEP_STOP_SDA_HI: sda_q = 1'b1;
         STEP_STOP_END: begin
            scl_q = 1'b0;
            return 1'b1;
         end
         default: return 1'b1;
      endcase
      step = step + 5'd1;
      return 1'b0;
   endfunction

   // Advance the model by one request and return the pin and status state after it
   function automatic rsp_type pin_state_after(input req_type item);
      rsp_type r;
      logic    finished;
      logic    turned_away;
      finished    = 1'b0;
      turned_away = 1'b0;
      if (item.action == ACT_TICK) begin
         if (running) begin
            if (countdown > 16'd1) begin
               countdown = countdown - 16'd1;
            end else if (apply_pin_change(item.sda_in)) begin
               running   = 1'b0;
               step      = STEP_IDLE;
               countdown = '0;
               finished  = 1'b1;
            end else begin
               countdown = wait_len;
            end
         end
      end else if (item.action <= ACT_PROBE) begin
         if (running) begin
            turned_away = 1'b1;
         end else begin
            cmd       = item.action;
            running   = 1'b1;
            bit_pos   = '0;
            countdown = wait_len;
            case (item.action)
               ACT_STOP: step = STEP_STOP_SCL_LO;
               ACT_WRITE: begin
                  shreg = item.data_byte;
                  step  = STEP_BIT_SETUP;
               end
               ACT_READ: begin
                  shreg       = '0;
                  ack_to_send = item.ack_send;
                  step        = STEP_BIT_SETUP;
               end
               default: begin
                  if (item.action == ACT_PROBE) shreg = item.data_byte;
                  step = STEP_START_SCL_LO;
               end
            endcase
         end
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.sda_drive = ~sda_float;
      r.busy_res  = running;
      r.done_res  = finished;
      r.rx_byte   = rx_last;
      r.ack_seen  = ack_q;
      r.rejected  = turned_away;
      return r;
   endfunction

   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   // Track the channels: csr writes, response checks, then new predictions
   always @(posedge clock) begin
      if (reset) begin
         wait_len    = PHASE_TICKS_RESET;
         countdown   = '0;
         step        = STEP_IDLE;
         bit_pos     = '0;
         shreg       = '0;
         cmd         = ACT_TICK;
         ack_to_send = 1'b0;
         scl_q       = 1'b1;
         sda_q       = 1'b1;
         sda_float   = 1'b0;
         ack_q       = 1'b1;
         running     = 1'b0;
         rx_last     = '0;
         mismatches  = 0;
         pin_state_q.delete();
      end else begin
         if (csr_valid && csr_ready) wait_len = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (pin_state_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response transfer with nothing expected: %0h",
                           $time, rsp_data);
            end else begin
               wanted = pin_state_q.pop_front();
               report_field("scl_level", 8'(wanted.scl_level), 8'(rsp_data.scl_level));
               report_field("sda_level", 8'(wanted.sda_level), 8'(rsp_data.sda_level));
               report_field("sda_drive", 8'(wanted.sda_drive), 8'(rsp_data.sda_drive));
               report_field("busy_res",  8'(wanted.busy_res),  8'(rsp_data.busy_res));
               report_field("done_res",  8'(wanted.done_res),  8'(rsp_data.done_res));
               report_field("rx_byte",   wanted.rx_byte,       rsp_data.rx_byte);
               report_field("ack_seen",  8'(wanted.ack_seen),  8'(rsp_data.ack_seen));
               report_field("rejected",  8'(wanted.rejected),  8'(rsp_data.rejected));
            end
         end
         if (req_valid && req_ready) pin_state_q.push_back(pin_state_after(req_data));
      end
      outstanding <= pin_state_q.size();
      seq_busy    <= running;
   end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives command and tick transfers into the sequencer with random idling,
// back pressure and several phase lengths, and lets the checker compare
// every response against its own model of the pins and status.
// ----------------------------------------------------------------------------
module tb;
   import i2cms_pkg::*;

   // Action codes the block ignores
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   // Wait phases per command
   localparam int unsigned START_PHASES = 6;
   localparam int unsigned STOP_PHASES  = 5;
   localparam int unsigned BYTE_PHASES  = 27;
   localparam int unsigned PROBE_PHASES = 38;

   localparam int unsigned STALL_CYCLES = 60;
   localparam int unsigned RUN_LIMIT    = 4_000_000;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   int unsigned mismatches;
   int unsigned outstanding;
   logic        seq_busy;

   logic [15:0] cur_wait    = PHASE_TICKS_RESET;
   bit          calm        = 1'b0;
   bit          stall_asked = 1'b0;
   int unsigned items_sent  = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   i2c_master_bit_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   i2cms_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .seq_busy    (seq_busy)
   );

   // Response side: random stalls, or a long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (stall_asked) begin
            rsp_ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
            stall_asked = 1'b0;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 16);
      end
   end

   function automatic req_type make_req(input logic [2:0] act, input logic [7:0] data,
                                        input logic ack, input logic sda);
      req_type r;
      r.action    = act;
      r.data_byte = data;
      r.ack_send  = ack;
      r.sda_in    = sda;
      return r;
   endfunction

   function automatic int unsigned phases_needed(input logic [2:0] act);
      case (act)
         ACT_START: return START_PHASES;
         ACT_STOP:  return STOP_PHASES;
         ACT_WRITE: return BYTE_PHASES;
         ACT_READ:  return BYTE_PHASES;
         ACT_PROBE: return PROBE_PHASES;
         default:   return 0;
      endcase
   endfunction

   // Offer one request, idling first at random, and hold it until the transfer
   task automatic send_req(input req_type item);
      if (!calm) begin
         while ($urandom_range(99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_tick();
      send_req(make_req(ACT_TICK, 8'($urandom), 1'($urandom), 1'($urandom)));
   endtask

   // Send a random command code, including the ignored ones
   task automatic send_any_cmd();
      send_req(make_req(3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                        1'($urandom)));
   endtask

   // Tick until the running command has finished
   task automatic settle();
      do send_tick(); while (seq_busy);
   endtask

   // Drop valid and wait for every response to come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_phase_ticks(input logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_wait = value;
   endtask

   // Issue a command and tick it to completion, with stray commands mixed in
   task automatic run_sequence(input logic [2:0] act, input logic [7:0] data,
                               input logic ack);
      int unsigned ticks;
      settle();
      send_req(make_req(act, data, ack, 1'($urandom)));
      ticks = phases_needed(act) * ((cur_wait == 0) ? 1 : cur_wait);
      repeat (ticks) begin
         if ($urandom_range(99) < 5)
            send_req(make_req(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom),
                              1'($urandom)));
         send_tick();
      end
   endtask

   // Mostly whole commands, some noise and some cut-short commands
   task automatic random_phase(input int unsigned count);
      int unsigned first;
      int unsigned pick;
      logic [2:0]  act;
      first = items_sent;
      while (items_sent - first < count) begin
         pick = $urandom_range(99);
         act  = 3'($urandom_range(ACT_START, ACT_PROBE));
         if (pick < 70) begin
            run_sequence(act, 8'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            repeat ($urandom_range(4, 12)) begin
               if ($urandom_range(1)) send_tick();
               else send_any_cmd();
            end
         end else begin
            send_req(make_req(act, 8'($urandom), 1'($urandom), 1'($urandom)));
            repeat ($urandom_range(phases_needed(act) * ((cur_wait == 0) ? 1 : cur_wait)))
               send_tick();
         end
      end
   endtask

   // Stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Idle ticks, spare codes, and every command while busy
      send_req(make_req(ACT_TICK, 8'h00, 1'b0, 1'b0));
      send_req(make_req(ACT_TICK, 8'hFF, 1'b1, 1'b1));
      send_req(make_req(ACT_SPARE_6, 8'hFF, 1'b1, 1'b1));
      send_req(make_req(ACT_SPARE_7, 8'h00, 1'b0, 1'b0));
      send_req(make_req(ACT_STOP, 8'hFF, 1'b1, 1'b1));
      send_req(make_req(ACT_START, 8'h00, 1'b0, 1'b0));
      send_req(make_req(ACT_STOP, 8'h00, 1'b0, 1'b1));
      send_req(make_req(ACT_WRITE, 8'hFF, 1'b1, 1'b0));
      send_req(make_req(ACT_READ, 8'h00, 1'b1, 1'b1));
      send_req(make_req(ACT_PROBE, 8'hA5, 1'b0, 1'b0));
      send_tick();
      send_tick();
      settle();

      // Zero phase length: every wait lasts a single tick
      set_phase_ticks(16'd0);
      run_sequence(ACT_START, 8'h00, 1'b0);
      run_sequence(ACT_WRITE, 8'hFF, 1'b0);
      run_sequence(ACT_WRITE, 8'h00, 1'b1);
      run_sequence(ACT_READ, 8'h00, 1'b0);
      run_sequence(ACT_READ, 8'hFF, 1'b1);
      run_sequence(ACT_PROBE, 8'h5A, 1'b0);
      run_sequence(ACT_STOP, 8'hFF, 1'b1);

      set_phase_ticks(16'd1);
      random_phase(50);

      // Hold the response side off while requests keep coming
      set_phase_ticks(16'd2);
      calm = 1'b1;
      stall_asked = 1'b1;
      repeat (40) begin
         if ($urandom_range(3) != 0) send_tick();
         else send_any_cmd();
      end
      calm = 1'b0;
      drain();
      random_phase(30);

      // No idling on either side
      set_phase_ticks(16'd3);
      calm = 1'b1;
      random_phase(30);
      calm = 1'b0;

      set_phase_ticks(16'($urandom_range(4, 6)));
      random_phase(30);

      set_phase_ticks(16'd0);
      random_phase(30);

      // Longest phase: the command stays busy, so later commands are turned away
      settle();
      set_phase_ticks(16'hFFFF);
      send_req(make_req(ACT_STOP, 8'($urandom), 1'($urandom), 1'($urandom)));
      repeat (20) send_tick();
      send_req(make_req(ACT_START, 8'hFF, 1'b1, 1'b1));
      send_req(make_req(ACT_WRITE, 8'h00, 1'b0, 1'b0));
      send_req(make_req(ACT_READ, 8'hFF, 1'b1, 1'b0));
      send_req(make_req(ACT_PROBE, 8'h00, 1'b0, 1'b1));
      send_req(make_req(ACT_SPARE_7, 8'hFF, 1'b1, 1'b1));
      repeat (5) send_tick();

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("i2c_master_bit_sequencer regression: pass");
      end else begin
         $display("i2c_master_bit_sequencer regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT);
      $display("i2c_master_bit_sequencer regression: fail");
      $finish;
   end

endmodule
